### sv/mshw_pkg.sv
// ----------------------------------------------------------------------------
// mshw_pkg - shared types for the multi-slot heartbeat watchdog
// Operation codes, slot status codes and the per-slot update record.
// ----------------------------------------------------------------------------
package mshw_pkg;

  // default table depth
  localparam int unsigned SLOTS_DEF = 16;

  // operation codes carried with each input transaction
  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_REMOVE = 3'd1,
    FN_PING   = 3'd2,
    FN_FINISH = 3'd3,
    FN_CHECK  = 3'd4,
    FN_CLEAR  = 3'd5
  } func_e;

  // status of one monitored unit
  typedef enum logic [1:0] {
    STS_UP       = 2'd0,
    STS_DOWN     = 2'd1,
    STS_ROGUE    = 2'd2,
    STS_FINISHED = 2'd3
  } status_e;

  // update decided for one slot by the shared slot unit
  typedef struct packed {
    logic    wr;        // write used bit and status back
    logic    used_n;    // new used bit
    status_e status_n;  // new status
    logic    inc;       // count goes up by one
    logic    dec;       // count goes down by one
    logic    sweep;     // unit turned rogue
    logic    ok;        // slot operation succeeded
  } slot_res_t;

endpackage

### sv/mshw_slot_alu.sv
// ----------------------------------------------------------------------------
// mshw_slot_alu - per-slot update unit
// Decides the new used bit, status and count change of the slot in hand.
// ----------------------------------------------------------------------------
module mshw_slot_alu (
  input  mshw_pkg::func_e     func_i,
  input  logic                used_i,
  input  mshw_pkg::status_e   status_i,
  output mshw_pkg::slot_res_t res_o
);

  always_comb begin
    res_o          = '0;
    res_o.used_n   = used_i;
    res_o.status_n = status_i;
    unique case (func_i)
      mshw_pkg::FN_ADD: begin
        // claim a free slot
        if (!used_i) begin
          res_o.wr       = 1'b1;
          res_o.used_n   = 1'b1;
          res_o.status_n = mshw_pkg::STS_UP;
          res_o.inc      = 1'b1;
          res_o.ok       = 1'b1;
        end
      end
      mshw_pkg::FN_REMOVE: begin
        if (used_i) begin
          res_o.wr       = 1'b1;
          res_o.used_n   = 1'b0;
          res_o.status_n = mshw_pkg::STS_UP;
          res_o.dec      = 1'b1;
          res_o.ok       = 1'b1;
        end
      end
      mshw_pkg::FN_PING: begin
        if (used_i) begin
          res_o.wr       = 1'b1;
          res_o.status_n = mshw_pkg::STS_UP;
          res_o.ok       = 1'b1;
        end
      end
      mshw_pkg::FN_FINISH: begin
        if (used_i) begin
          res_o.wr       = 1'b1;
          res_o.status_n = mshw_pkg::STS_FINISHED;
          res_o.ok       = 1'b1;
        end
      end
      mshw_pkg::FN_CHECK: begin
        // age the unit; rogue and finished stay as they are
        if (used_i && status_i == mshw_pkg::STS_UP) begin
          res_o.wr       = 1'b1;
          res_o.status_n = mshw_pkg::STS_DOWN;
        end else if (used_i && status_i == mshw_pkg::STS_DOWN) begin
          res_o.wr       = 1'b1;
          res_o.status_n = mshw_pkg::STS_ROGUE;
          res_o.sweep    = 1'b1;
        end
      end
      mshw_pkg::FN_CLEAR: begin
        // drop rogue and finished units
        if (used_i && (status_i == mshw_pkg::STS_ROGUE ||
                       status_i == mshw_pkg::STS_FINISHED)) begin
          res_o.wr       = 1'b1;
          res_o.used_n   = 1'b0;
          res_o.status_n = mshw_pkg::STS_UP;
          res_o.dec      = 1'b1;
        end
      end
      default: begin
        res_o.wr = 1'b0;
      end
    endcase
  end

endmodule

### sv/multi_slot_heartbeat_watchdog_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_heartbeat_watchdog_unit - heartbeat watchdog over a slot table
// Tracks SLOTS monitored units: add, remove, ping, finish, check, clear.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: func; tdata: slot_index
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: ok, given_slot, sweep,
//                                               unit_total
//
// Operation: add, check and clear walk the table one slot a cycle through the
//   shared slot unit and the status memory read port (add stops at the first
//   free slot); remove, ping and finish visit only their own slot, and none
//   for a slot beyond the table; an unknown code visits no slot.
// Reset: asynchronous, active low; clears the used bits and the count at once,
//   so the table is usable as soon as reset is released.
// Stalls: a result waits in the output register while the next transaction is
//   taken; a finished transaction holds until that register is free.
//
module multi_slot_heartbeat_watchdog_unit #(
  parameter int unsigned SLOTS = mshw_pkg::SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] slot_index, [7:4] zero
  input  logic [7:0]  s_axis_tuser,   // [2:0] func, [7:3] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] ok, [4:1] given_slot, [5] sweep,
                                      // [10:6] unit_total, [15:11] zero
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned XI_W  = (IDX_W > 4) ? IDX_W : 4;
  localparam int unsigned XC_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [XI_W:0]    SLOTS_X   = (XI_W + 1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  // control
  state_e                 state_q, state_d;
  mshw_pkg::func_e        op_q, op_d;
  logic [IDX_W-1:0]       cur_q, cur_d;
  logic [IDX_W-1:0]       end_q, end_d;
  logic                   a_done_q, a_done_d;
  logic                   b_vld_q, b_vld_d;
  logic                   found_q, found_d;
  logic [SLOTS-1:0]       used_q, used_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   m_vld_q, m_vld_d;

  // payload
  logic [IDX_W-1:0]       b_slot_q, b_slot_d;
  logic [IDX_W-1:0]       given_q, given_d;
  logic                   ok_q, ok_d;
  logic                   sweep_q, sweep_d;
  logic [1:0]             rd_q;
  logic                   out_ok_q, out_ok_d;
  logic [3:0]             out_given_q, out_given_d;
  logic                   out_sweep_q, out_sweep_d;
  logic [4:0]             out_total_q, out_total_d;

  logic [1:0]             status_mem [SLOTS];

  logic                   s_accept;
  mshw_pkg::func_e        func_w;
  logic [XI_W-1:0]        idx_x;
  logic                   in_range;
  logic                   b_live;
  logic                   done;
  logic                   out_free;
  logic                   mem_we;
  logic [XI_W-1:0]        given_x;
  logic [XC_W-1:0]        count_x;
  mshw_pkg::slot_res_t    res;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign func_w        = mshw_pkg::func_e'(s_axis_tuser[2:0]);
  assign idx_x         = XI_W'(s_axis_tdata[3:0]);
  assign in_range      = ({1'b0, idx_x} < SLOTS_X);

  // stage B works on the slot read in the previous cycle; kill it after a claim
  assign b_live   = b_vld_q & ~found_q;
  assign done     = (a_done_q | found_q) & ~b_vld_q;
  assign out_free = ~m_vld_q | m_axis_tready;
  assign mem_we   = b_live & res.wr;

  mshw_slot_alu u_alu (
    .func_i   (op_q),
    .used_i   (used_q[b_slot_q]),
    .status_i (mshw_pkg::status_e'(rd_q)),
    .res_o    (res)
  );

  assign given_x = XI_W'(given_q);
  assign count_x = XC_W'(count_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cur_d       = cur_q;
    end_d       = end_q;
    a_done_d    = a_done_q;
    b_vld_d     = 1'b0;
    b_slot_d    = b_slot_q;
    found_d     = found_q;
    used_d      = used_q;
    count_d     = count_q;
    given_d     = given_q;
    ok_d        = ok_q;
    sweep_d     = sweep_q;
    m_vld_d     = m_vld_q & ~m_axis_tready;
    out_ok_d    = out_ok_q;
    out_given_d = out_given_q;
    out_sweep_d = out_sweep_q;
    out_total_d = out_total_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          op_d     = func_w;
          found_d  = 1'b0;
          given_d  = '0;
          sweep_d  = 1'b0;
          ok_d     = 1'b0;
          cur_d    = '0;
          end_d    = LAST_SLOT;
          a_done_d = 1'b0;
          case (func_w) inside
            mshw_pkg::FN_ADD: begin
              a_done_d = 1'b0;
            end
            mshw_pkg::FN_CHECK, mshw_pkg::FN_CLEAR: begin
              ok_d = 1'b1;
            end
            mshw_pkg::FN_REMOVE, mshw_pkg::FN_PING, mshw_pkg::FN_FINISH: begin
              // one slot only; out of range gives nothing to visit
              cur_d    = idx_x[IDX_W-1:0];
              end_d    = idx_x[IDX_W-1:0];
              a_done_d = ~in_range;
            end
            default: begin
              a_done_d = 1'b1;
            end
          endcase
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        // stage A: issue the next slot to the status read port
        if (!a_done_q && !found_q) begin
          b_vld_d  = 1'b1;
          b_slot_d = cur_q;
          if (cur_q == end_q) begin
            a_done_d = 1'b1;
          end else begin
            cur_d = IDX_W'(cur_q + 1'b1);
          end
        end
        // stage B: apply the slot unit's decision
        if (b_live) begin
          if (res.wr) begin
            used_d[b_slot_q] = res.used_n;
          end
          count_d = CNT_W'(count_q + CNT_W'(res.inc) - CNT_W'(res.dec));
          sweep_d = sweep_q | res.sweep;
          if (op_q == mshw_pkg::FN_ADD && res.ok) begin
            found_d = 1'b1;
            given_d = b_slot_q;
            ok_d    = 1'b1;
          end
          if (op_q == mshw_pkg::FN_REMOVE || op_q == mshw_pkg::FN_PING ||
              op_q == mshw_pkg::FN_FINISH) begin
            ok_d = res.ok;
          end
        end
        // post the result once the walk has drained and the output is free
        if (done && out_free) begin
          m_vld_d     = 1'b1;
          out_ok_d    = ok_q;
          out_given_d = given_x[3:0];
          out_sweep_d = sweep_q;
          out_total_d = count_x[4:0];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= mshw_pkg::FN_ADD;
      cur_q    <= '0;
      end_q    <= '0;
      a_done_q <= 1'b1;
      b_vld_q  <= 1'b0;
      found_q  <= 1'b0;
      used_q   <= '0;
      count_q  <= '0;
      m_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      cur_q    <= cur_d;
      end_q    <= end_d;
      a_done_q <= a_done_d;
      b_vld_q  <= b_vld_d;
      found_q  <= found_d;
      used_q   <= used_d;
      count_q  <= count_d;
      m_vld_q  <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_slot_q    <= b_slot_d;
    given_q     <= given_d;
    ok_q        <= ok_d;
    sweep_q     <= sweep_d;
    out_ok_q    <= out_ok_d;
    out_given_q <= out_given_d;
    out_sweep_q <= out_sweep_d;
    out_total_q <= out_total_d;
  end

  // status memory: registered read at the cursor, write back from stage B
  always_ff @(posedge clk_i) begin
    rd_q <= status_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      status_mem[b_slot_q] <= res.status_n;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {5'b0, out_total_q, out_sweep_q, out_given_q, out_ok_q};

  // count tracks the used bits
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'($countones(used_q)))
    else $error("used count out of step with used bits");

  // the walk has drained whenever a new transaction can be taken
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !b_vld_q)
    else $error("slot pipeline busy while idle");

  // a claim only ends an add, and the claimed slot is then in use
  a_claim_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(found_q) |-> op_q == mshw_pkg::FN_ADD && used_q[given_q])
    else $error("slot claim outside add");

endmodule
